### hw/rtl/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

    localparam int SEG_W               = 9;
    localparam int IDX_W               = 17;
    localparam int COORD_W             = 16;
    localparam int PHASE_W             = 32;
    localparam int VAL_W               = 32;
    localparam int PROD_W              = 64;
    localparam int PROD_FRAC           = 60;
    localparam int SEG_RESET           = 16;
    localparam int MAX_SEGMENTS_DEF    = 256;
    localparam int COORD_FRAC_BITS_DEF = 15;

    localparam int DIV_STEP   = 4;
    localparam int DIV_LAT    = (PHASE_W + DIV_STEP - 1) / DIV_STEP;

    localparam int CORDIC_STEPS  = 30;
    localparam int CORDIC_STEP   = 2;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS + CORDIC_STEP - 1) / CORDIC_STEP;
    localparam int CORDIC_LAT    = CORDIC_ITERS + 2;
    localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int CELL_WORDS = 6;
    localparam int K_W        = 3;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_CELL   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              bad;
        logic [IDX_W-1:0]  base;
    } side_t;

    // Angle of atan(2^-i) in units of 2^-32 turn
    function automatic logic [PHASE_W-1:0] turn_atan(input int i);
        logic [PHASE_W-1:0] a;
        unique case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;
            15: a = 32'h0000517C;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A2F;
            19: a = 32'h00000517;
            20: a = 32'h0000028B;
            21: a = 32'h00000145;
            22: a = 32'h000000A2;
            23: a = 32'h00000051;
            24: a = 32'h00000028;
            25: a = 32'h00000014;
            26: a = 32'h0000000A;
            27: a = 32'h00000005;
            28: a = 32'h00000002;
            29: a = 32'h00000001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/uvs_div.sv
`default_nettype none

// Pipelined restoring divider: low word of (rem_in * 2^32 + num_lo) / den, rem_in < den
module uvs_div #(
    parameter int DEN_W = uvs_pkg::SEG_W + 1
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [DEN_W-1:0]            den,
    input  wire logic [uvs_pkg::PHASE_W-1:0] num_lo,
    input  wire logic [DEN_W-1:0]            rem_in,
    output logic      [uvs_pkg::PHASE_W-1:0] quot
);

    localparam int QW   = uvs_pkg::PHASE_W;
    localparam int STEP = uvs_pkg::DIV_STEP;
    localparam int NST  = uvs_pkg::DIV_LAT;

    logic [DEN_W-1:0] rem_reg  [NST];
    logic [QW-1:0]    q_reg    [NST];
    logic [DEN_W-1:0] rem_prev [NST];
    logic [QW-1:0]    q_prev   [NST];
    logic [DEN_W-1:0] rem_next [NST];
    logic [QW-1:0]    q_next   [NST];

    always_comb
    begin
        rem_prev[0] = rem_in;
        q_prev[0]   = '0;
        for (int s = 1; s < NST; s++)
        begin
            rem_prev[s] = rem_reg[s-1];
            q_prev[s]   = q_reg[s-1];
        end
    end

    always_comb
    begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [QW-1:0]    q;
        for (int s = 0; s < NST; s++)
        begin
            r = rem_prev[s];
            q = q_prev[s];
            for (int j = 0; j < STEP; j++)
            begin
                if (s * STEP + j < QW)
                begin
                    t = {r, num_lo[QW-1-(s*STEP+j)]};
                    if (t >= {1'b0, den})
                    begin
                        r = DEN_W'(t - {1'b0, den});
                        q = {q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r = DEN_W'(t);
                        q = {q[QW-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = r;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    assign quot = q_reg[NST-1];

endmodule

`default_nettype wire

### hw/rtl/uvs_cordic.sv
`default_nettype none

// Pipelined rotation-mode CORDIC: cos and sin of a phase in turns, Q2.30 results
module uvs_cordic (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic        [uvs_pkg::PHASE_W-1:0] phase,
    output logic signed      [uvs_pkg::VAL_W-1:0]   cos_val,
    output logic signed      [uvs_pkg::VAL_W-1:0]   sin_val
);

    localparam int VW   = uvs_pkg::VAL_W;
    localparam int PW   = uvs_pkg::PHASE_W;
    localparam int STEP = uvs_pkg::CORDIC_STEP;
    localparam int NST  = uvs_pkg::CORDIC_ITERS;
    localparam int NIT  = uvs_pkg::CORDIC_STEPS;

    logic [1:0]           q0_reg;
    logic signed [PW-1:0] z0_reg;
    logic [PW-1:0]        half_q;

    logic signed [VW-1:0] x_reg [NST];
    logic signed [VW-1:0] y_reg [NST];
    logic signed [PW-1:0] z_reg [NST];
    logic [1:0]           q_reg [NST];

    logic signed [VW-1:0] x_prev [NST];
    logic signed [VW-1:0] y_prev [NST];
    logic signed [PW-1:0] z_prev [NST];
    logic [1:0]           q_prev [NST];
    logic signed [VW-1:0] x_next [NST];
    logic signed [VW-1:0] y_next [NST];
    logic signed [PW-1:0] z_next [NST];

    logic signed [VW-1:0] cos_reg;
    logic signed [VW-1:0] sin_reg;

    assign half_q = phase + 32'h2000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg <= half_q[PW-1:PW-2];
            z0_reg <= $signed(phase - {half_q[PW-1:PW-2], {(PW-2){1'b0}}});
        end
    end

    always_comb
    begin
        x_prev[0] = uvs_pkg::CORDIC_GAIN;
        y_prev[0] = '0;
        z_prev[0] = z0_reg;
        q_prev[0] = q0_reg;
        for (int s = 1; s < NST; s++)
        begin
            x_prev[s] = x_reg[s-1];
            y_prev[s] = y_reg[s-1];
            z_prev[s] = z_reg[s-1];
            q_prev[s] = q_reg[s-1];
        end
    end

    always_comb
    begin
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] nx;
        logic signed [PW-1:0] z;
        for (int s = 0; s < NST; s++)
        begin
            x = x_prev[s];
            y = y_prev[s];
            z = z_prev[s];
            for (int j = 0; j < STEP; j++)
            begin
                if (s * STEP + j < NIT)
                begin
                    if (z >= 0)
                    begin
                        nx = x - (y >>> (s * STEP + j));
                        y  = y + (x >>> (s * STEP + j));
                        z  = z - $signed(uvs_pkg::turn_atan(s * STEP + j));
                    end
                    else
                    begin
                        nx = x + (y >>> (s * STEP + j));
                        y  = y - (x >>> (s * STEP + j));
                        z  = z + $signed(uvs_pkg::turn_atan(s * STEP + j));
                    end
                    x = nx;
                end
            end
            x_next[s] = x;
            y_next[s] = y;
            z_next[s] = z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                x_reg[s] <= x_next[s];
                y_reg[s] <= y_next[s];
                z_reg[s] <= z_next[s];
                q_reg[s] <= q_prev[s];
            end
        end
    end

    // Turn the residual result by whole quarter turns
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[NST-1])
                2'd0:
                begin
                    cos_reg <= x_reg[NST-1];
                    sin_reg <= y_reg[NST-1];
                end
                2'd1:
                begin
                    cos_reg <= -y_reg[NST-1];
                    sin_reg <= x_reg[NST-1];
                end
                2'd2:
                begin
                    cos_reg <= -x_reg[NST-1];
                    sin_reg <= -y_reg[NST-1];
                end
                default:
                begin
                    cos_reg <= y_reg[NST-1];
                    sin_reg <= -x_reg[NST-1];
                end
            endcase
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

### hw/rtl/uv_sphere_mesh_generator_core.sv
`default_nettype none

// UV-sphere mesh generator.
// Input stream (s_*): one request word; tuser is the mode (0 vertex, 1 cell),
// tdata carries row and col. Output stream (m_*): result words; tdata holds
// pos_x, pos_y, pos_z and vertex_index, tuser is bad_request, tlast marks the
// final word of a request.
// Configuration (cfg_*): write the segment count S; cfg_ready is always high.
// Write it only while no request is in flight.
// A vertex request yields one word, a cell request six index words, and an
// out-of-range request one word with bad_request set and all values zero.
// The input register loads on the accepting edge; then come the 8-stage phase
// divider (4 quotient bits per stage), the 17-stage CORDIC (setup, 15 stages
// of two rotations, quarter turn), one multiply stage and the output register.
// Throughput: one vertex request per cycle while m_tready is high; a cell request
// holds the output register until its six words are taken, and stalls the
// pipeline behind it. With a word held and m_tready low, the whole pipeline
// freezes with its valid bits, so no word is lost or repeated; s_tready drops
// until the output word is taken.
// Reset clears all valid bits and sets S to 16.
module uv_sphere_mesh_generator_core #(
    parameter int MAX_SEGMENTS    = uvs_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_FRAC_BITS = uvs_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // row[8:0], col[17:9], zero pad
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // pos_x, pos_y, pos_z, vertex_index, zero pad
    output logic             m_tuser,   // bad_request
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data   // segments
);

    localparam int SW     = uvs_pkg::SEG_W;
    localparam int IW     = uvs_pkg::IDX_W;
    localparam int CW     = uvs_pkg::COORD_W;
    localparam int PW     = uvs_pkg::PHASE_W;
    localparam int DW     = SW + 1;
    localparam int NPIPE  = 1 + uvs_pkg::DIV_LAT + uvs_pkg::CORDIC_LAT + 1;
    localparam int SH     = uvs_pkg::PROD_FRAC - COORD_FRAC_BITS;
    localparam longint HALF   = longint'(1) << (SH - 1);
    localparam longint HI_RAW = (longint'(1) << COORD_FRAC_BITS) - 1;
    localparam longint LO_RAW = -(longint'(1) << COORD_FRAC_BITS);
    localparam longint SAT_HI = (HI_RAW > 32767) ? 32767 : HI_RAW;
    localparam longint SAT_LO = (LO_RAW < -32768) ? -32768 : LO_RAW;

    logic [SW-1:0] seg_reg;

    logic [SW-1:0] row_in;
    logic [SW-1:0] col_in;
    logic          mode_in;
    logic          bad_in;
    logic [19:0]   base_full;
    logic          adv;

    uvs_pkg::side_t side_reg [NPIPE];
    logic           vld_reg  [NPIPE];
    logic [DW-1:0]  prem_reg;
    logic [DW-1:0]  yrem_reg;

    logic [PW-1:0]  pitch_q;
    logic [PW-1:0]  yaw_q;
    logic signed [uvs_pkg::VAL_W-1:0] cp, sp, cy, sy;
    logic signed [uvs_pkg::PROD_W-1:0] px_reg, py_reg, pz_reg;

    logic           o_valid_reg;
    uvs_pkg::side_t o_side_reg;
    logic [CW-1:0]  o_x_reg, o_y_reg, o_z_reg;
    logic [uvs_pkg::K_W-1:0] o_k_reg;
    logic           o_last;
    logic [SW+1:0]  idx_off;
    logic [IW-1:0]  idx_out;

    assign row_in  = s_tdata[8:0];
    assign col_in  = s_tdata[17:9];
    assign mode_in = s_tuser;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= SW'(uvs_pkg::SEG_RESET);
        else if (cfg_valid)
            seg_reg <= cfg_data;
    end

    // Range check and cell base index at the input
    always_comb
    begin
        if (seg_reg == '0 || 32'(seg_reg) > 32'(MAX_SEGMENTS))
            bad_in = 1'b1;
        else if (mode_in == uvs_pkg::MODE_VERTEX)
            bad_in = (row_in > seg_reg) || (col_in > seg_reg);
        else
            bad_in = (row_in >= seg_reg) || (col_in >= seg_reg);
    end

    assign base_full = 20'(row_in) * 20'(10'(seg_reg) + 10'd1) + 20'(col_in);

    // Freeze everything while the output word waits
    assign adv      = !o_valid_reg || (m_tready && o_last);
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPIPE; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NPIPE; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= '{mode: mode_in, bad: bad_in, base: IW'(base_full)};
            for (int i = 1; i < NPIPE; i++)
                side_reg[i] <= side_reg[i-1];
            // Integer part of the numerator is already below the divisor;
            // a yaw column equal to S wraps to phase zero
            prem_reg <= DW'(row_in);
            yrem_reg <= (col_in == seg_reg) ? '0 : DW'(col_in);
        end
    end

    // Pitch phase: (v*2^32 + S) / (2S); yaw phase: (u*2^32 + S/2) / S
    uvs_div #(.DEN_W(DW)) u_div_pitch (
        .clk    (clk),
        .en     (adv),
        .den    ({seg_reg, 1'b0}),
        .num_lo (PW'(seg_reg)),
        .rem_in (prem_reg),
        .quot   (pitch_q)
    );

    uvs_div #(.DEN_W(DW)) u_div_yaw (
        .clk    (clk),
        .en     (adv),
        .den    ({1'b0, seg_reg}),
        .num_lo (PW'(seg_reg >> 1)),
        .rem_in (yrem_reg),
        .quot   (yaw_q)
    );

    uvs_cordic u_cordic_pitch (
        .clk     (clk),
        .en      (adv),
        .phase   (pitch_q - 32'h4000_0000),
        .cos_val (cp),
        .sin_val (sp)
    );

    uvs_cordic u_cordic_yaw (
        .clk     (clk),
        .en      (adv),
        .phase   (yaw_q),
        .cos_val (cy),
        .sin_val (sy)
    );

    // Q4.60 products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= 64'(cy) * 64'(cp);
            pz_reg <= 64'(sy) * 64'(cp);
            py_reg <= $signed({{2{sp[uvs_pkg::VAL_W-1]}}, sp, 30'b0});
        end
    end

    // Round half up, then clamp to the coordinate range
    function automatic logic [CW-1:0] to_coord(input logic signed [uvs_pkg::PROD_W-1:0] p);
        logic signed [uvs_pkg::PROD_W-1:0] r;
        r = (p + HALF) >>> SH;
        if (r > SAT_HI)
            r = SAT_HI;
        if (r < SAT_LO)
            r = SAT_LO;
        return r[CW-1:0];
    endfunction

    // Output register and cell word counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            o_k_reg     <= '0;
        end
        else if (adv)
        begin
            o_valid_reg <= vld_reg[NPIPE-1];
            o_k_reg     <= '0;
        end
        else if (m_tready)
        begin
            o_k_reg <= o_k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_side_reg <= side_reg[NPIPE-1];
            o_x_reg    <= to_coord(px_reg);
            o_y_reg    <= to_coord(py_reg);
            o_z_reg    <= to_coord(pz_reg);
        end
    end

    assign o_last = o_side_reg.bad || (o_side_reg.mode == uvs_pkg::MODE_VERTEX)
                    || (32'(o_k_reg) == uvs_pkg::CELL_WORDS - 1);

    // Corner offsets of the two triangles: b, b+1, b+S+1, b+S+2, b+S+1, b+1
    always_comb
    begin
        unique case (o_k_reg)
            3'd0:    idx_off = '0;
            3'd1:    idx_off = 11'd1;
            3'd2:    idx_off = 11'(seg_reg) + 11'd1;
            3'd3:    idx_off = 11'(seg_reg) + 11'd2;
            3'd4:    idx_off = 11'(seg_reg) + 11'd1;
            default: idx_off = 11'd1;
        endcase
    end

    assign idx_out = IW'(18'(o_side_reg.base) + 18'(idx_off));

    always_comb
    begin
        m_tdata = '0;
        if (!o_side_reg.bad)
        begin
            if (o_side_reg.mode == uvs_pkg::MODE_VERTEX)
            begin
                m_tdata[15:0]  = o_x_reg;
                m_tdata[31:16] = o_y_reg;
                m_tdata[47:32] = o_z_reg;
            end
            else
            begin
                m_tdata[64:48] = idx_out;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_side_reg.bad;
    assign m_tlast  = o_last;

`ifndef SYNTHESIS
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("bad request word without last");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_count_cell_only: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_k_reg != '0 |-> o_side_reg.mode == uvs_pkg::MODE_CELL
                                         && !o_side_reg.bad)
        else $error("word counter moved on a single-word result");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
module tb_top;

    localparam int LATENCY = 28;

    // Result word as seen on the output stream
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [16:0]        vertex_index;
        logic               bad_request;
        logic               last;
    } mesh_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // row[8:0], col[17:9], zero pad
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // pos_x, pos_y, pos_z, vertex_index, zero pad
    logic        m_tuser;   // bad_request
    logic        m_tlast;   // last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;  // segments

    mesh_word_t  expected_words[$];
    logic [8:0]  seg_count;
    int          error_count;
    bit          quiet_tail;   // no idle bursts on the input side in the last part
    bit          stall_enable;

    uv_sphere_mesh_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor(v / 2^s) for signed values
    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    // Rotate by the phase residual, then by whole quarter turns; Q2.30 results
    function automatic void turn_sincos(input logic [31:0] phase,
                                        output longint c, output longint s);
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      z;
        longint      x;
        longint      y;
        longint      nx;
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - ({30'd0, quad} << 30);
        z = longint'(resid);
        if (z >= 64'sh8000_0000)
            z -= 64'sh1_0000_0000;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shift_floor(y, i);
                y  = y + shift_floor(x, i);
                z -= longint'(uvs_pkg::turn_atan(i));
            end
            else
            begin
                nx = x + shift_floor(y, i);
                y  = y - shift_floor(x, i);
                z += longint'(uvs_pkg::turn_atan(i));
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // Q4.60 to Q1.15, round half up, saturate
    function automatic logic [15:0] q60_to_coord(longint v60);
        longint r;
        r = (v60 + (64'sd1 <<< 44)) >>> 45;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // Push the words a request should produce under the current segment count
    task automatic predict_mesh(input logic mode, input logic [8:0] row,
                                input logic [8:0] col);
        longint      segs;
        bit          bad;
        mesh_word_t  w;
        logic [31:0] pitch_ph;
        logic [31:0] yaw_ph;
        longint      cp;
        longint      sp;
        longint      cy;
        longint      sy;
        longint      base;
        longint      corner[6];
        segs = seg_count;
        w = '0;
        if (segs == 0 || segs > uvs_pkg::MAX_SEGMENTS_DEF)
            bad = 1'b1;
        else if (mode == uvs_pkg::MODE_VERTEX)
            bad = (row > segs) || (col > segs);
        else
            bad = (row >= segs) || (col >= segs);
        if (bad)
        begin
            w.bad_request = 1'b1;
            w.last = 1'b1;
            expected_words.push_back(w);
        end
        else if (mode == uvs_pkg::MODE_VERTEX)
        begin
            pitch_ph = 32'(((longint'(row) << 32) + segs) / (2 * segs)) - 32'h4000_0000;
            yaw_ph   = 32'(((longint'(col) << 32) + segs / 2) / segs);
            turn_sincos(pitch_ph, cp, sp);
            turn_sincos(yaw_ph, cy, sy);
            w.pos_x = q60_to_coord(cy * cp);
            w.pos_y = q60_to_coord(sp <<< 30);
            w.pos_z = q60_to_coord(sy * cp);
            w.last = 1'b1;
            expected_words.push_back(w);
        end
        else
        begin
            base = longint'(row) * (segs + 1) + col;
            corner = '{base, base + 1, base + segs + 1, base + segs + 2,
                       base + segs + 1, base + 1};
            for (int k = 0; k < 6; k++)
            begin
                w = '0;
                w.vertex_index = corner[k][16:0];
                w.last = (k == 5);
                expected_words.push_back(w);
            end
        end
    endtask

    // Send one request word, with an occasional idle burst before it
    task automatic send_request(input logic mode, input logic [8:0] row,
                                input logic [8:0] col);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_mesh(mode, row, col);
        @(negedge clk);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_segments(input logic [8:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        seg_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-range requests, some at the edge row and column S, some anywhere
    task automatic random_request;
        logic       mode;
        logic [8:0] row;
        logic [8:0] col;
        int         lim;
        mode = 1'($urandom_range(0, 1));
        lim  = (seg_count == 0) ? 0 : seg_count;
        case ($urandom_range(0, 9))
            0: begin row = 9'($urandom); col = 9'($urandom); end
            1: begin row = 9'(lim); col = 9'(lim); end
            default:
            begin
                row = 9'($urandom_range(0, lim));
                col = 9'($urandom_range(0, lim));
            end
        endcase
        send_request(mode, row, col);
    endtask

    task automatic test_reset_segments;
        send_request(uvs_pkg::MODE_VERTEX, 9'd0, 9'd0);
        send_request(uvs_pkg::MODE_VERTEX, 9'd16, 9'd16);
        send_request(uvs_pkg::MODE_VERTEX, 9'd8, 9'd4);
        send_request(uvs_pkg::MODE_VERTEX, 9'd17, 9'd0);
        send_request(uvs_pkg::MODE_VERTEX, 9'd0, 9'd17);
        send_request(uvs_pkg::MODE_CELL, 9'd0, 9'd0);
        send_request(uvs_pkg::MODE_CELL, 9'd15, 9'd15);
        send_request(uvs_pkg::MODE_CELL, 9'd16, 9'd0);
        send_request(uvs_pkg::MODE_CELL, 9'd0, 9'd16);
        send_request(uvs_pkg::MODE_VERTEX, 9'h1FF, 9'h1FF);
        send_request(uvs_pkg::MODE_CELL, 9'h1FF, 9'h1FF);
    endtask

    task automatic test_segment_extremes;
        write_segments(9'd256);
        send_request(uvs_pkg::MODE_VERTEX, 9'd256, 9'd256);
        send_request(uvs_pkg::MODE_VERTEX, 9'd128, 9'd64);
        send_request(uvs_pkg::MODE_VERTEX, 9'd255, 9'd1);
        send_request(uvs_pkg::MODE_CELL, 9'd255, 9'd255);
        send_request(uvs_pkg::MODE_CELL, 9'd256, 9'd0);
        send_request(uvs_pkg::MODE_VERTEX, 9'd257, 9'd0);
        write_segments(9'd1);
        send_request(uvs_pkg::MODE_VERTEX, 9'd1, 9'd1);
        send_request(uvs_pkg::MODE_CELL, 9'd0, 9'd0);
        send_request(uvs_pkg::MODE_CELL, 9'd1, 9'd0);
        write_segments(9'd0);
        send_request(uvs_pkg::MODE_VERTEX, 9'd0, 9'd0);
        write_segments(9'd300);
        send_request(uvs_pkg::MODE_CELL, 9'd0, 9'd0);
        write_segments(9'h1FF);
        send_request(uvs_pkg::MODE_VERTEX, 9'd1, 9'd1);
    endtask

    task automatic test_random_mix;
        int settings[5] = '{3, 256, 7, 100, 16};
        foreach (settings[p])
        begin
            write_segments(9'(settings[p]));
            for (int n = 0; n < 70; n++)
            begin
                random_request();
                // hold off until everything has come back
                if (n == 35)
                    drain_results();
            end
        end
    endtask

    task automatic test_full_rate;
        write_segments(9'd37);
        quiet_tail = 1'b1;
        stall_enable = 1'b0;
        for (int n = 0; n < 60; n++)
            random_request();
        drain_results();
    endtask

    // Output side: random backpressure bursts, then steady ready at the end
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_enable && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each taken word against the oldest expectation
    initial
    begin
        mesh_word_t got;
        mesh_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = {m_tdata[64:0], m_tuser, m_tlast};
                got.pos_x = m_tdata[15:0];
                got.pos_y = m_tdata[31:16];
                got.pos_z = m_tdata[47:32];
                got.vertex_index = m_tdata[64:48];
                got.bad_request = m_tuser;
                got.last = m_tlast;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, got %p", $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        error_count  = 0;
        seg_count    = 9'(uvs_pkg::SEG_RESET);
        quiet_tail   = 1'b0;
        stall_enable = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_segments();
        test_segment_extremes();
        test_random_mix();
        test_full_rate();
        if (error_count == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div.sv
hw/rtl/uvs_cordic.sv
hw/rtl/uv_sphere_mesh_generator_core.sv
sim/tb_top.sv
